[rtl/core/twli_pkg.sv]
`default_nettype none
package twli_pkg;
   localparam int MaxWaypoints = 64;
   localparam int CoordWidth   = 32;
   localparam int TimeWidth    = 32;

   typedef enum logic [1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_QUERY  = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_DUP    = 2'd1,
      ST_FULL   = 2'd2,
      ST_NO_SEG = 2'd3
   } status_type;
endpackage
`default_nettype wire

[rtl/core/twli_ram.sv]
`default_nettype none
module twli_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[rtl/core/twli_div.sv]
`default_nettype none
// Restoring divider: quotient of an unsigned numerator, one bit a cycle; the remainder is not output.
module twli_div #(
   parameter int NumWidth = 64,
   parameter int DenWidth = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [NumWidth-1:0] num,
   input  wire logic [DenWidth-1:0] den,
   output logic                     done,
   output logic      [NumWidth-1:0] quot
);
   localparam int CntWidth = $clog2(NumWidth + 1);

   logic [NumWidth-1:0] q_ff, q_in;
   logic [DenWidth:0]   r_ff, r_in;
   logic [DenWidth-1:0] d_ff, d_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;
   logic [DenWidth:0]   trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {r_ff[DenWidth-1:0], q_ff[NumWidth-1]};
      if (start) begin
         q_in = num;
         r_in = '0;
         d_in = den;
         cnt_in = CntWidth'(NumWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NumWidth-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NumWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

[rtl/core/timed_waypoint_linear_interpolator.sv]
`default_nettype none
// Timed waypoint table with piecewise linear 3D interpolation.
// The req_ channel carries one command beat: clear, insert a waypoint at its
// time-sorted place, or query the position at a time. Every request beat
// yields exactly one rsp_ beat with a status, a position, the segment used
// and the number of waypoints held afterwards.
// The waypoints live in four synchronous RAMs (time, x, y, z) with a
// registered read port. An insert first scans down from the top entry to find
// its slot and to detect a duplicate time, then moves the entries above the
// slot up by one place and writes the new entry.
// A query scans segments upward, then runs three bit-serial divisions, one
// per axis. A clear or an unused mode goes from accept straight to the output
// stage.
// One item is handled at a time. A finished result sits in the output
// register while the next beat is accepted and worked on; if the receiver
// still stalls when that next result is ready, the block waits and the req_
// channel stays blocked until the output register is taken.
// Reset empties the table at once (the count goes to zero); no clearing pass
// is needed because only entries below the count are ever read.
module timed_waypoint_linear_interpolator #(
   parameter int MAX_WAYPOINTS = twli_pkg::MaxWaypoints,
   parameter int COORD_WIDTH   = twli_pkg::CoordWidth
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // mode[1:0], time_tick[33:2], pos_x[65:34], pos_y[97:66], pos_z[129:98], zeros
   input  wire logic [135:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status[1:0], out_x[33:2], out_y[65:34], out_z[97:66],
   // segment_index[103:98], entry_count[110:104], zeros
   output logic      [111:0] rsp_tdata
);
   localparam int AW = $clog2(MAX_WAYPOINTS);
   localparam int CW = $clog2(MAX_WAYPOINTS + 1);
   localparam int TW = twli_pkg::TimeWidth;
   localparam int DW = COORD_WIDTH + 1;   // width of a coordinate difference
   localparam int NW = DW + TW;           // width of difference times elapsed time

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_INS_RD = 9'b000000010,
      S_INS_CK = 9'b000000100,
      S_INS_WR = 9'b000001000,
      S_Q_RD   = 9'b000010000,
      S_Q_CK   = 9'b000100000,
      S_Q_DIV  = 9'b001000000,
      S_Q_DIVW = 9'b010000000,
      S_OUT    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Request fields.
   logic [1:0]  req_mode;
   logic [TW-1:0] req_time;
   logic signed [31:0] req_x, req_y, req_z;
   assign req_mode = req_tdata[1:0];
   assign req_time = req_tdata[33:2];
   assign req_x = req_tdata[65:34];
   assign req_y = req_tdata[97:66];
   assign req_z = req_tdata[129:98];

   logic [TW-1:0] t_ff, t_in;
   logic [COORD_WIDTH-1:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] idx_ff, idx_in;      // scan position
   logic [CW-1:0] pos_ff, pos_in;      // slot of the new entry
   logic          mv_ff, mv_in;        // insert is moving entries up
   logic [1:0] axis_ff, axis_in;

   // Previous- and current-entry latches for the query scan.
   logic [TW-1:0] t0_ff, t0_in;
   logic [COORD_WIDTH-1:0] x0_ff, x0_in, y0_ff, y0_in, z0_ff, z0_in;
   logic [COORD_WIDTH-1:0] x1_ff, x1_in, y1_ff, y1_in, z1_ff, z1_in;
   logic [TW-1:0] den_ff, den_in, num_ff, num_in;

   // Working result.
   logic [1:0] rs_ff, rs_in;
   logic [31:0] rx_ff, rx_in, ry_ff, ry_in, rz_ff, rz_in;
   logic [5:0] rseg_ff, rseg_in;

   // Output register.
   logic       rv_ff, rv_in;
   logic [1:0] os_ff, os_in;
   logic [31:0] ox_ff, ox_in, oy_ff, oy_in, oz_ff, oz_in;
   logic [5:0] oseg_ff, oseg_in;
   logic [6:0] ocnt_ff, ocnt_in;

   // RAM ports.
   logic          we;
   logic [AW-1:0] wa, ra;
   logic [TW-1:0] wt, rt;
   logic [COORD_WIDTH-1:0] wx, wy, wz, rdx, rdy, rdz;

   twli_ram #(.Width(TW), .Depth(MAX_WAYPOINTS)) u_ram_t (
      .clock, .wr_en(we), .wr_addr(wa), .wr_data(wt), .rd_addr(ra), .rd_data(rt));
   twli_ram #(.Width(COORD_WIDTH), .Depth(MAX_WAYPOINTS)) u_ram_x (
      .clock, .wr_en(we), .wr_addr(wa), .wr_data(wx), .rd_addr(ra), .rd_data(rdx));
   twli_ram #(.Width(COORD_WIDTH), .Depth(MAX_WAYPOINTS)) u_ram_y (
      .clock, .wr_en(we), .wr_addr(wa), .wr_data(wy), .rd_addr(ra), .rd_data(rdy));
   twli_ram #(.Width(COORD_WIDTH), .Depth(MAX_WAYPOINTS)) u_ram_z (
      .clock, .wr_en(we), .wr_addr(wa), .wr_data(wz), .rd_addr(ra), .rd_data(rdz));

   // Divider: |P1-P0| * num / den. The product is formed combinationally from a
   // DW x TW multiply, registered, and then divided serially, one axis at a time.
   logic            div_start, div_done;
   logic [NW-1:0]   div_num, div_q;
   logic signed [DW-1:0] diff;
   logic [DW-1:0]   diff_mag;
   logic            diff_neg_ff, diff_neg_in;
   logic [NW-1:0]   prod_ff, prod_in;
   logic [COORD_WIDTH-1:0] base_ff, base_in;
   logic [COORD_WIDTH-1:0] cur_p0, cur_p1;

   twli_div #(.NumWidth(NW), .DenWidth(TW)) u_div (
      .clock, .reset, .start(div_start), .num(div_num), .den(den_ff),
      .done(div_done), .quot(div_q));

   assign req_tready = state_ff[0];
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {1'b0, ocnt_ff, oseg_ff, oz_ff, oy_ff, ox_ff, os_ff};

   always_comb begin
      unique case (axis_ff)
         2'd0:    begin cur_p0 = x0_ff; cur_p1 = x1_ff; end
         2'd1:    begin cur_p0 = y0_ff; cur_p1 = y1_ff; end
         default: begin cur_p0 = z0_ff; cur_p1 = z1_ff; end
      endcase
   end

   logic [NW-1:0] prod_full;
   assign diff = DW'($signed(cur_p1)) - DW'($signed(cur_p0));
   assign diff_mag = diff[DW-1] ? DW'(-diff) : DW'(diff);
   assign prod_full = NW'(diff_mag) * NW'(num_ff);
   assign div_num = prod_ff;

   logic [COORD_WIDTH-1:0] lerp;
   assign lerp = diff_neg_ff ? base_ff - COORD_WIDTH'(div_q)
                             : base_ff + COORD_WIDTH'(div_q);

   function automatic logic [31:0] to32(input logic [COORD_WIDTH-1:0] v);
      return 32'($signed(v));
   endfunction

   always_comb begin
      state_in = state_ff;
      t_in = t_ff; px_in = px_ff; py_in = py_ff; pz_in = pz_ff;
      cnt_in = cnt_ff; idx_in = idx_ff; axis_in = axis_ff;
      pos_in = pos_ff; mv_in = mv_ff;
      t0_in = t0_ff; x0_in = x0_ff; y0_in = y0_ff; z0_in = z0_ff;
      x1_in = x1_ff; y1_in = y1_ff; z1_in = z1_ff;
      den_in = den_ff; num_in = num_ff;
      rs_in = rs_ff; rx_in = rx_ff; ry_in = ry_ff; rz_in = rz_ff;
      rseg_in = rseg_ff;
      rv_in = rv_ff; os_in = os_ff; ox_in = ox_ff; oy_in = oy_ff; oz_in = oz_ff;
      oseg_in = oseg_ff; ocnt_in = ocnt_ff;
      diff_neg_in = diff_neg_ff; prod_in = prod_ff; base_in = base_ff;
      we = 1'b0; wa = '0; wt = t_ff; wx = px_ff; wy = py_ff; wz = pz_ff;
      ra = AW'(idx_ff);
      div_start = 1'b0;
      if (rv_ff && rsp_tready) rv_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               t_in = req_time;
               px_in = COORD_WIDTH'(req_x);
               py_in = COORD_WIDTH'(req_y);
               pz_in = COORD_WIDTH'(req_z);
               rs_in = twli_pkg::ST_OK;
               rx_in = '0; ry_in = '0; rz_in = '0; rseg_in = '0;
               unique case (req_mode)
                  twli_pkg::MODE_CLEAR: begin
                     cnt_in = '0;
                     state_in = S_OUT;
                  end
                  twli_pkg::MODE_INSERT: begin
                     // Walk down from the top entry to find the slot; nothing
                     // is moved until the duplicate and full checks pass.
                     idx_in = cnt_ff;
                     mv_in = 1'b0;
                     state_in = S_INS_RD;
                  end
                  twli_pkg::MODE_QUERY: begin
                     idx_in = '0;
                     state_in = S_Q_RD;
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         // Insert: read entry idx-1. While searching, compare its time; while
         // moving, copy it up to idx. At the slot the new entry is written.
         S_INS_RD: begin
            if (mv_ff && idx_ff == pos_ff) begin
               we = 1'b1;
               wa = AW'(idx_ff);
               cnt_in = cnt_ff + 1'b1;
               state_in = S_OUT;
            end else if (!mv_ff && idx_ff == '0) begin
               state_in = S_INS_WR;
            end else begin
               ra = AW'(idx_ff - 1'b1);
               state_in = S_INS_CK;
            end
         end
         S_INS_CK: begin
            if (mv_ff) begin
               we = 1'b1;
               wa = AW'(idx_ff);
               wt = rt; wx = rdx; wy = rdy; wz = rdz;
               idx_in = idx_ff - 1'b1;
               state_in = S_INS_RD;
            end else if (rt == t_ff) begin
               rs_in = twli_pkg::ST_DUP;
               state_in = S_OUT;
            end else if (rt > t_ff) begin
               idx_in = idx_ff - 1'b1;
               state_in = S_INS_RD;
            end else begin
               state_in = S_INS_WR;
            end
         end
         S_INS_WR: begin
            if (cnt_ff >= CW'(MAX_WAYPOINTS)) begin
               rs_in = twli_pkg::ST_FULL;
               state_in = S_OUT;
            end else begin
               pos_in = idx_ff;
               idx_in = cnt_ff;
               mv_in = 1'b1;
               state_in = S_INS_RD;
            end
         end
         // Query: read entry idx, compare with previous entry's time.
         S_Q_RD: begin
            if (idx_ff >= cnt_ff) begin
               rs_in = twli_pkg::ST_NO_SEG;
               state_in = S_OUT;
            end else begin
               ra = AW'(idx_ff);
               state_in = S_Q_CK;
            end
         end
         S_Q_CK: begin
            if (idx_ff != '0 && t_ff >= t0_ff && t_ff <= rt) begin
               x1_in = rdx; y1_in = rdy; z1_in = rdz;
               num_in = t_ff - t0_ff;
               den_in = rt - t0_ff;
               rseg_in = 6'(idx_ff - 1'b1);
               axis_in = 2'd0;
               state_in = S_Q_DIV;
            end else if (idx_ff == cnt_ff - 1'b1 && rt == t_ff) begin
               rx_in = to32(rdx); ry_in = to32(rdy); rz_in = to32(rdz);
               rseg_in = 6'(idx_ff);
               state_in = S_OUT;
            end else begin
               t0_in = rt; x0_in = rdx; y0_in = rdy; z0_in = rdz;
               idx_in = idx_ff + 1'b1;
               state_in = S_Q_RD;
            end
         end
         S_Q_DIV: begin
            prod_in = prod_full;
            diff_neg_in = diff[DW-1];
            base_in = cur_p0;
            state_in = S_Q_DIVW;
            idx_in = '0;
         end
         S_Q_DIVW: begin
            if (idx_ff == '0) begin
               div_start = 1'b1;
               idx_in = CW'(1);
            end else if (div_done) begin
               idx_in = '0;
               unique case (axis_ff)
                  2'd0:    rx_in = to32(lerp);
                  2'd1:    ry_in = to32(lerp);
                  default: rz_in = to32(lerp);
               endcase
               if (axis_ff == 2'd2) begin
                  state_in = S_OUT;
               end else begin
                  axis_in = axis_ff + 1'b1;
                  state_in = S_Q_DIV;
               end
            end
         end
         // Hand the result to the output register once it is free.
         S_OUT: begin
            if (!rv_ff || rsp_tready) begin
               rv_in = 1'b1;
               os_in = rs_ff;
               ox_in = rx_ff; oy_in = ry_ff; oz_in = rz_ff;
               oseg_in = rseg_ff;
               ocnt_in = 7'(cnt_ff);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in; px_ff <= px_in; py_ff <= py_in; pz_ff <= pz_in;
      idx_ff <= idx_in; axis_ff <= axis_in;
      pos_ff <= pos_in; mv_ff <= mv_in;
      t0_ff <= t0_in; x0_ff <= x0_in; y0_ff <= y0_in; z0_ff <= z0_in;
      x1_ff <= x1_in; y1_ff <= y1_in; z1_ff <= z1_in;
      den_ff <= den_in; num_ff <= num_in;
      rs_ff <= rs_in; rx_ff <= rx_in; ry_ff <= ry_in; rz_ff <= rz_in;
      rseg_ff <= rseg_in;
      os_ff <= os_in; ox_ff <= ox_in; oy_ff <= oy_in; oz_ff <= oz_in;
      oseg_ff <= oseg_in; ocnt_ff <= ocnt_in;
      diff_neg_ff <= diff_neg_in; prod_ff <= prod_in; base_ff <= base_in;
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rv_ff <= rv_in;
      end
   end
endmodule
`default_nettype wire
